>>> src/som_pkg.sv
// Shared types, codes and constant tables of the self-organising map trainer.
package som_pkg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SWAIT,
        ST_UPD,
        ST_UWAIT,
        ST_READ,
        ST_DONE
    } t_state;

    // Item kinds carried in tuser.
    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_TRAIN = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_TOPOLOGY      = 2'd2;
    localparam logic [1:0] CFG_LEARNING_RATE = 2'd3;

    // Neighbour sets.
    localparam logic [1:0] TOPO_CROSS = 2'd0;
    localparam logic [1:0] TOPO_DIAG  = 2'd1;

    // Weight axes handled by the shared unit.
    typedef logic [1:0] t_axis;
    localparam t_axis AX_X = 2'd0;
    localparam t_axis AX_Y = 2'd1;
    localparam t_axis AX_Z = 2'd2;

    // Fixed field widths.
    localparam int NODE_IDX_W  = 6;
    localparam int COLOR_W     = 24;
    localparam int SCORE_OUT_W = 33;
    localparam int LR_W        = 9;
    localparam int CFG_DATA_W  = 9;

    // Learning rate of 1.0 in Q1.8.
    localparam logic [LR_W-1:0] LR_ONE = 9'd256;

    // Row and column offsets of the eight neighbours: cross first, then the corners.
    localparam logic signed [1:0] NB_DR [8] = '{
        -2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1
    };
    localparam logic signed [1:0] NB_DC [8] = '{
        2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, 2'sd1, -2'sd1
    };

    // One operation for the shared multiply unit.
    typedef struct packed {
        logic  vld;
        logic  upd;
        t_axis axis;
    } t_alu_ctl;

endpackage

>>> src/som_ram.sv
// Generic single-write, single-read RAM with registered read data.
module som_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/som_alu.sv
// Shared multiply unit: dot-product accumulation and rounded, saturated weight update.
module som_alu #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  som_pkg::t_alu_ctl            i_ctl,
    input  logic [3*COORD_BITS-1:0]      i_w,
    input  logic [3*COORD_BITS-1:0]      i_s,
    input  logic [som_pkg::LR_W-1:0]     i_lr,
    output logic signed [2*COORD_BITS:0] o_score,
    output logic                         o_score_vld,
    output logic [3*COORD_BITS-1:0]      o_word,
    output logic                         o_word_vld
);

    localparam int CB = COORD_BITS;
    localparam int MW = CB + 2;
    localparam int PW = 2 * MW;
    localparam int SW = 2 * CB + 1;
    localparam logic signed [MW-1:0] HI = MW'((1 << (CB - 1)) - 1);
    localparam logic signed [MW-1:0] LO = -MW'(1 << (CB - 1));

    logic signed [CB-1:0]        w_sel;
    logic signed [CB-1:0]        s_sel;
    logic [som_pkg::LR_W-1:0]    lr_eff;
    logic signed [MW-1:0]        op_a;
    logic signed [MW-1:0]        op_b;
    logic signed [PW-1:0]        prod;

    som_pkg::t_alu_ctl           r_ctl2;
    logic signed [PW-1:0]        r_prod;
    logic signed [CB-1:0]        r_w2;
    logic signed [SW-1:0]        r_acc;
    logic [CB-1:0]               r_nx;
    logic [CB-1:0]               r_ny;

    logic signed [SW-1:0]        sum;
    logic signed [PW-1:0]        rnd;
    logic signed [PW-1:0]        delta;
    logic signed [MW-1:0]        nw;
    logic signed [MW-1:0]        nw_sat;

    always_comb begin
        unique case (i_ctl.axis)
            som_pkg::AX_X: begin
                w_sel = i_w[0 +: CB];
                s_sel = i_s[0 +: CB];
            end
            som_pkg::AX_Y: begin
                w_sel = i_w[CB +: CB];
                s_sel = i_s[CB +: CB];
            end
            som_pkg::AX_Z: begin
                w_sel = i_w[2*CB +: CB];
                s_sel = i_s[2*CB +: CB];
            end
            default: begin
                w_sel = '0;
                s_sel = '0;
            end
        endcase
    end

    assign lr_eff = (i_lr > som_pkg::LR_ONE) ? som_pkg::LR_ONE : i_lr;

    // Score: weight times sample. Update: (sample - weight) times gain.
    always_comb begin
        if (i_ctl.upd) begin
            op_a = MW'(s_sel) - MW'(w_sel);
            op_b = $signed(MW'(lr_eff));
        end else begin
            op_a = MW'(w_sel);
            op_b = MW'(s_sel);
        end
    end

    assign prod = op_a * op_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl2 <= '0;
        end else begin
            r_ctl2 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_w2   <= w_sel;
        if (r_ctl2.vld && !r_ctl2.upd) begin
            r_acc <= sum;
        end
        if (r_ctl2.vld && r_ctl2.upd && r_ctl2.axis == som_pkg::AX_X) begin
            r_nx <= nw_sat[CB-1:0];
        end
        if (r_ctl2.vld && r_ctl2.upd && r_ctl2.axis == som_pkg::AX_Y) begin
            r_ny <= nw_sat[CB-1:0];
        end
    end

    // Second stage: accumulate, or round half up, add and saturate.
    assign sum   = ((r_ctl2.axis == som_pkg::AX_X) ? '0 : r_acc) + SW'(r_prod);
    assign rnd   = r_prod + PW'(128);
    assign delta = rnd >>> 8;
    assign nw    = MW'(r_w2) + MW'(delta);

    always_comb begin
        if (nw > HI) begin
            nw_sat = HI;
        end else if (nw < LO) begin
            nw_sat = LO;
        end else begin
            nw_sat = nw;
        end
    end

    assign o_score     = sum;
    assign o_score_vld = r_ctl2.vld && !r_ctl2.upd && (r_ctl2.axis == som_pkg::AX_Z);
    assign o_word      = {nw_sat[CB-1:0], r_ny, r_nx};
    assign o_word_vld  = r_ctl2.vld && r_ctl2.upd && (r_ctl2.axis == som_pkg::AX_Z);

endmodule

>>> src/self_organizing_map_trainer.sv
// Top level of the self-organising map trainer: sequencer, node stores and stream ports.
//
//  Channel   Direction  Handshake                 Contents
//  s (item)  in         i_s_tvalid / o_s_tready   tuser: kind; tdata: node, sample, colour
//  m (result) out       o_m_tvalid / i_m_tready   tdata: node, score, weights, colour
//  cfg       in         i_cfg_valid / o_cfg_ready register index and write data
//
// A train item scores every node and then updates the winner and its neighbours that
// lie in the grid and the topology, all through the single shared multiplier, one
// axis a cycle. After reset a clearing pass over all MAX_SIDE*MAX_SIDE entries paints
// every colour entry white, and no item is taken meanwhile. A result beat waits in the
// output register while the next item is accepted; only its completion waits for a
// free slot.
module self_organizing_map_trainer #(
    parameter int MAX_SIDE   = 8,
    parameter int COORD_BITS = 16,
    localparam int IN_W  = ((30 + 3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((63 + 3 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Items.
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // tdata from bit 0: node_index, sample_x, sample_y, sample_z,
    // sample_red, sample_green, sample_blue, zero padding
    input  logic [IN_W-1:0]                  i_s_tdata,
    // tuser: mode
    input  logic [1:0]                       i_s_tuser,
    // Results.
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // tdata from bit 0: result_node, best_score, weight_x, weight_y, weight_z,
    // node_red, node_green, node_blue, zero padding
    output logic [OUT_W-1:0]                 o_m_tdata,
    // Configuration writes.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [1:0]                       i_cfg_index,
    input  logic [som_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CB         = COORD_BITS;
    localparam int NODE_COUNT = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W     = $clog2(NODE_COUNT);
    localparam int POS_W      = $clog2(MAX_SIDE);
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int RW         = POS_W + 2;
    localparam int SW         = 2 * CB + 1;
    localparam int WW         = 3 * CB;
    localparam int CW         = som_pkg::COLOR_W;

    // Configuration registers.
    logic [3:0]                 r_grid_width;
    logic [3:0]                 r_grid_height;
    logic [1:0]                 r_topology;
    logic [som_pkg::LR_W-1:0]   r_lr;

    // Sequencer state and counters.
    som_pkg::t_state            r_state, n_state;
    logic [ADDR_W-1:0]          r_clr, n_clr;
    logic [ADDR_W-1:0]          r_node, n_node;
    logic [POS_W-1:0]           r_row, n_row;
    logic [POS_W-1:0]           r_col, n_col;
    som_pkg::t_axis             r_axis, n_axis;
    logic [3:0]                 r_k, n_k;
    logic                       r_is_train, n_is_train;

    // Item held for the duration of its work.
    logic [som_pkg::NODE_IDX_W-1:0] r_idx;
    logic [WW-1:0]              r_s;
    logic [CW-1:0]              r_rgb;

    // Operation pipeline: issue, RAM read, product, result.
    som_pkg::t_alu_ctl          ctl0;
    som_pkg::t_alu_ctl          r_ctl1;
    logic [ADDR_W-1:0]          raddr;
    logic [POS_W-1:0]           tag0_row, tag0_col;
    logic [ADDR_W-1:0]          r_t1_addr, r_t2_addr;
    logic [POS_W-1:0]           r_t1_row, r_t2_row, r_t1_col, r_t2_col;

    // Winner tracking.
    logic [ADDR_W-1:0]          r_best_addr;
    logic [POS_W-1:0]           r_best_row, r_best_col;
    logic signed [SW-1:0]       r_best_score;
    logic [WW-1:0]              r_best_word;

    // Output register.
    logic                       r_out_vld, n_out_vld;
    logic [OUT_W-1:0]           r_out_data;
    logic                       out_load;

    // Input fields.
    logic [1:0]                     in_mode;
    logic [som_pkg::NODE_IDX_W-1:0] in_idx;
    logic [WW-1:0]                  in_s;
    logic [CW-1:0]                  in_rgb;
    logic                           in_ok;
    logic                           accept;

    // Grid size in use.
    logic [SIDE_W-1:0]          cw, ch, cw_m1, ch_m1;
    logic [ADDR_W-1:0]          cw_a;

    // Neighbour candidate.
    logic [2:0]                 nb_j;
    logic                       nb_self;
    logic signed [1:0]          nb_dr, nb_dc;
    logic                       nb_topo;
    logic signed [RW-1:0]       nb_r, nb_c;
    logic                       nb_ok;
    logic [ADDR_W-1:0]          nb_addr;

    // Stores.
    logic                       w_we, c_we;
    logic [ADDR_W-1:0]          w_waddr, c_waddr;
    logic [WW-1:0]              w_wdata, w_rdata;
    logic [CW-1:0]              c_wdata, c_rdata;

    // Shared unit results.
    logic signed [SW-1:0]       alu_score;
    logic                       alu_score_vld;
    logic [WW-1:0]              alu_word;
    logic                       alu_word_vld;

    assign in_mode = i_s_tuser;
    assign in_idx  = i_s_tdata[som_pkg::NODE_IDX_W-1:0];
    assign in_s    = i_s_tdata[som_pkg::NODE_IDX_W +: WW];
    assign in_rgb  = i_s_tdata[som_pkg::NODE_IDX_W + WW +: CW];
    // Loads and reads beyond the store are dropped.
    assign in_ok   = int'(in_idx) < NODE_COUNT;

    assign o_s_tready  = (r_state == som_pkg::ST_IDLE);
    assign accept      = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Grid sides are clamped to the range the store supports.
    always_comb begin
        if (int'(r_grid_width) < 2) begin
            cw = SIDE_W'(2);
        end else if (int'(r_grid_width) > MAX_SIDE) begin
            cw = SIDE_W'(MAX_SIDE);
        end else begin
            cw = SIDE_W'(r_grid_width);
        end
        if (int'(r_grid_height) < 2) begin
            ch = SIDE_W'(2);
        end else if (int'(r_grid_height) > MAX_SIDE) begin
            ch = SIDE_W'(MAX_SIDE);
        end else begin
            ch = SIDE_W'(r_grid_height);
        end
    end

    assign cw_m1 = cw - SIDE_W'(1);
    assign ch_m1 = ch - SIDE_W'(1);
    assign cw_a  = ADDR_W'(cw);

    // The update pass walks k = 0 for the winner itself, then k = 1..8 over the
    // neighbour table, skipping entries outside the topology or the grid.
    assign nb_j    = 3'(r_k - 4'd1);
    assign nb_self = (r_k == 4'd0);
    assign nb_dr   = nb_self ? 2'sd0 : som_pkg::NB_DR[nb_j];
    assign nb_dc   = nb_self ? 2'sd0 : som_pkg::NB_DC[nb_j];

    always_comb begin
        if (nb_self) begin
            nb_topo = 1'b1;
        end else begin
            unique case (r_topology)
                som_pkg::TOPO_CROSS: nb_topo = !nb_j[2];
                som_pkg::TOPO_DIAG:  nb_topo = nb_j[2];
                default:             nb_topo = 1'b1;
            endcase
        end
    end

    assign nb_r  = $signed(RW'(r_best_row)) + RW'(nb_dr);
    assign nb_c  = $signed(RW'(r_best_col)) + RW'(nb_dc);
    assign nb_ok = nb_topo && (nb_r >= 0) && (nb_c >= 0)
                && (nb_r < $signed(RW'(ch))) && (nb_c < $signed(RW'(cw)));

    // Row steps move by one grid width; the sum wraps correctly for in-grid targets.
    always_comb begin
        if (nb_dr < 0) begin
            nb_addr = r_best_addr - cw_a + ADDR_W'(nb_dc);
        end else if (nb_dr > 0) begin
            nb_addr = r_best_addr + cw_a + ADDR_W'(nb_dc);
        end else begin
            nb_addr = r_best_addr + ADDR_W'(nb_dc);
        end
    end

    // Next state, counters and operation issue.
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_node     = r_node;
        n_row      = r_row;
        n_col      = r_col;
        n_axis     = r_axis;
        n_k        = r_k;
        n_is_train = r_is_train;
        ctl0       = '0;
        raddr      = ADDR_W'(r_idx);
        tag0_row   = r_row;
        tag0_col   = r_col;
        out_load   = 1'b0;

        unique case (r_state)
            som_pkg::ST_CLEAR: begin
                n_clr = r_clr + ADDR_W'(1);
                if (r_clr == ADDR_W'(NODE_COUNT - 1)) begin
                    n_state = som_pkg::ST_IDLE;
                end
            end
            som_pkg::ST_IDLE: begin
                if (accept) begin
                    n_node = '0;
                    n_row  = '0;
                    n_col  = '0;
                    n_axis = som_pkg::AX_X;
                    if (in_mode == som_pkg::MODE_TRAIN) begin
                        n_is_train = 1'b1;
                        n_state    = som_pkg::ST_SCAN;
                    end else if (in_mode == som_pkg::MODE_READ && in_ok) begin
                        n_is_train = 1'b0;
                        n_state    = som_pkg::ST_READ;
                    end
                end
            end
            som_pkg::ST_SCAN: begin
                // One axis of one node per cycle; the read address holds while all three axes are issued.
                raddr     = r_node;
                ctl0.vld  = 1'b1;
                ctl0.upd  = 1'b0;
                ctl0.axis = r_axis;
                if (r_axis == som_pkg::AX_Z) begin
                    n_axis = som_pkg::AX_X;
                    n_node = r_node + ADDR_W'(1);
                    if (SIDE_W'(r_col) == cw_m1) begin
                        n_col = '0;
                        n_row = r_row + POS_W'(1);
                        if (SIDE_W'(r_row) == ch_m1) begin
                            n_state = som_pkg::ST_SWAIT;
                        end
                    end else begin
                        n_col = r_col + POS_W'(1);
                    end
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            som_pkg::ST_SWAIT: begin
                // The last score settles the winner as the final operation drains.
                if (!r_ctl1.vld) begin
                    n_k     = '0;
                    n_axis  = som_pkg::AX_X;
                    n_state = som_pkg::ST_UPD;
                end
            end
            som_pkg::ST_UPD: begin
                raddr = nb_addr;
                if (nb_ok) begin
                    ctl0.vld  = 1'b1;
                    ctl0.upd  = 1'b1;
                    ctl0.axis = r_axis;
                end
                if (!nb_ok || r_axis == som_pkg::AX_Z) begin
                    n_axis = som_pkg::AX_X;
                    n_k    = r_k + 4'd1;
                    if (r_k == 4'd8) begin
                        n_state = som_pkg::ST_UWAIT;
                    end
                end else begin
                    n_axis = r_axis + 2'd1;
                end
            end
            som_pkg::ST_UWAIT: begin
                if (!r_ctl1.vld) begin
                    n_state = som_pkg::ST_DONE;
                end
            end
            som_pkg::ST_READ: begin
                n_state = som_pkg::ST_DONE;
            end
            som_pkg::ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = som_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = som_pkg::ST_IDLE;
            end
        endcase

        if (out_load) begin
            n_out_vld = 1'b1;
        end else if (i_m_tready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    // Store write ports: clearing, loading and the update pass never overlap.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = ADDR_W'(in_idx);
        w_wdata = in_s;
        c_we    = 1'b0;
        c_waddr = ADDR_W'(in_idx);
        c_wdata = '1;
        if (r_state == som_pkg::ST_CLEAR) begin
            c_we    = 1'b1;
            c_waddr = r_clr;
        end else if (accept && in_mode == som_pkg::MODE_LOAD && in_ok) begin
            w_we = 1'b1;
            c_we = 1'b1;
        end else if (alu_word_vld) begin
            w_we    = 1'b1;
            w_waddr = r_t2_addr;
            w_wdata = alu_word;
            c_we    = 1'b1;
            c_waddr = r_t2_addr;
            c_wdata = r_rgb;
        end
    end

    som_ram #(
        .WIDTH (WW),
        .DEPTH (NODE_COUNT)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (raddr),
        .o_rdata (w_rdata)
    );

    som_ram #(
        .WIDTH (CW),
        .DEPTH (NODE_COUNT)
    ) u_color_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_waddr),
        .i_wdata (c_wdata),
        .i_raddr (raddr),
        .o_rdata (c_rdata)
    );

    som_alu #(
        .COORD_BITS (COORD_BITS)
    ) u_alu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl1),
        .i_w         (w_rdata),
        .i_s         (r_s),
        .i_lr        (r_lr),
        .o_score     (alu_score),
        .o_score_vld (alu_score_vld),
        .o_word      (alu_word),
        .o_word_vld  (alu_word_vld)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= som_pkg::ST_CLEAR;
            r_clr         <= '0;
            r_node        <= '0;
            r_row         <= '0;
            r_col         <= '0;
            r_axis        <= som_pkg::AX_X;
            r_k           <= '0;
            r_is_train    <= 1'b0;
            r_ctl1        <= '0;
            r_out_vld     <= 1'b0;
            r_grid_width  <= 4'd8;
            r_grid_height <= 4'd8;
            r_topology    <= 2'd2;
            r_lr          <= 9'd128;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_node     <= n_node;
            r_row      <= n_row;
            r_col      <= n_col;
            r_axis     <= n_axis;
            r_k        <= n_k;
            r_is_train <= n_is_train;
            r_ctl1     <= ctl0;
            r_out_vld  <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    som_pkg::CFG_GRID_WIDTH:    r_grid_width  <= i_cfg_data[3:0];
                    som_pkg::CFG_GRID_HEIGHT:   r_grid_height <= i_cfg_data[3:0];
                    som_pkg::CFG_TOPOLOGY:      r_topology    <= i_cfg_data[1:0];
                    som_pkg::CFG_LEARNING_RATE: r_lr          <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= in_idx;
            r_s   <= in_s;
            r_rgb <= in_rgb;
        end
        r_t1_addr <= raddr;
        r_t1_row  <= tag0_row;
        r_t1_col  <= tag0_col;
        r_t2_addr <= r_t1_addr;
        r_t2_row  <= r_t1_row;
        r_t2_col  <= r_t1_col;
        // Node zero seeds the maximum; later nodes must beat it strictly.
        if (alu_score_vld && (r_t2_addr == '0 || alu_score > r_best_score)) begin
            r_best_addr  <= r_t2_addr;
            r_best_row   <= r_t2_row;
            r_best_col   <= r_t2_col;
            r_best_score <= alu_score;
        end
        if (alu_word_vld && r_t2_addr == r_best_addr) begin
            r_best_word <= alu_word;
        end
        if (out_load) begin
            if (r_is_train) begin
                r_out_data <= OUT_W'({r_rgb, r_best_word,
                                      som_pkg::SCORE_OUT_W'(r_best_score),
                                      som_pkg::NODE_IDX_W'(r_best_addr)});
            end else begin
                r_out_data <= OUT_W'({c_rdata, w_rdata,
                                      som_pkg::SCORE_OUT_W'(0), r_idx});
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule
